/* rtl/core/sound_register_log_encoder_defines.svh */
// Assertion helpers for the sound register log encoder.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef SOUND_REGISTER_LOG_ENCODER_DEFINES_SVH
`define SOUND_REGISTER_LOG_ENCODER_DEFINES_SVH

// Same-cycle implication
`define SLRE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SLRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/slre_pkg.sv */
`default_nettype none

package slre_pkg;

  // Register file geometry
  localparam int REG_SLOTS   = 16;
  localparam int LOGGED_REGS = 14;
  localparam int IDX_W       = $clog2(REG_SLOTS);
  localparam int LOG_IDX_W   = (LOGGED_REGS > 1) ? $clog2(LOGGED_REGS) : 1;

  // Output stream limits
  localparam int MAX_RESULTS = 32;
  localparam int BYTE_CNT_W  = $clog2(MAX_RESULTS);
  localparam int HDR_LEN     = 16;
  localparam int HDR_CNT_W   = $clog2(HDR_LEN);

  // Command queue
  localparam int CMD_DEPTH   = 2;
  localparam int CMD_PTR_W   = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);

  // Separator codes
  localparam logic [7:0] SEP_RUN   = 8'hfe;
  localparam logic [7:0] SEP_ONE   = 8'hff;
  localparam logic [7:0] RUN_LIMIT = 8'hff;
  localparam logic [7:0] RUN_ONE   = 8'h01;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_START = 2'd2,
    KIND_STOP  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR,
    PH_SEP1_TAG,
    PH_SEP1_CNT,
    PH_PAIR_IDX,
    PH_PAIR_VAL,
    PH_SEP2_TAG,
    PH_SEP2_CNT
  } back_phase_t;

  // One unit of work for the byte sequencer
  typedef struct packed {
    logic                             hdr;
    logic                             sep1_en;
    logic [7:0]                       sep1_run;
    logic [LOGGED_REGS-1:0]           marks;
    logic [LOGGED_REGS-1:0][7:0]      vals;
    logic                             sep2_en;
    logic [7:0]                       sep2_run;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Log file header: "PSG", 0x1a, then zeros
  function automatic logic [7:0] hdr_byte(input logic [HDR_CNT_W-1:0] pos);
    logic [7:0] b;
    case (pos)
      HDR_CNT_W'(0): b = 8'h50;
      HDR_CNT_W'(1): b = 8'h53;
      HDR_CNT_W'(2): b = 8'h47;
      HDR_CNT_W'(3): b = 8'h1a;
      default:       b = 8'h00;
    endcase
    return b;
  endfunction

  // Single frame gets FF, longer runs get FE then the count
  function automatic logic [7:0] sep_tag(input logic [7:0] run);
    return (run == RUN_ONE) ? SEP_ONE : SEP_RUN;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/slre_in_if.sv */
`default_nettype none

interface slre_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [3:0] reg_index;
  logic [7:0] reg_value;

  modport source (output valid, kind, reg_index, reg_value, input ready);
  modport sink (input valid, kind, reg_index, reg_value, output ready);
endinterface

`default_nettype wire

/* rtl/core/slre_out_if.sv */
`default_nettype none

interface slre_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);
endinterface

`default_nettype wire

/* rtl/core/slre_cmd_fifo.sv */
`default_nettype none

module slre_cmd_fifo import slre_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire cmd_t       push_cmd,
  input  wire logic       pop,
  output cmd_t            head,
  output fifo_stat_t      stat
);

  cmd_t                 mem_r [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r;
  logic [CMD_PTR_W-1:0] rd_ptr_r;
  logic [CMD_CNT_W-1:0] cnt_r;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CMD_CNT_W'(CMD_DEPTH));
  assign stat.empty = (cnt_r == '0);

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CMD_CNT_W'(push) - CMD_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/slre_front.sv */
`default_nettype none

module slre_front import slre_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  slre_in_if.sink         in_chan,
  input  wire fifo_stat_t stat,
  output logic            push,
  output cmd_t            push_cmd
);

  logic [REG_SLOTS-1:0]      marks_r;
  logic [REG_SLOTS-1:0][7:0] vals_r;
  logic [7:0]                run_r;
  logic                      rec_r;

  logic       acc;
  kind_t      kind;
  logic       any_logged;
  logic       tick_emit;
  logic [7:0] run_tick;

  assign in_chan.ready = !stat.full;
  assign acc           = in_chan.valid && in_chan.ready;
  assign kind          = kind_t'(in_chan.kind);

  // Classify the frame at a tick or stop
  assign any_logged = |marks_r[LOGGED_REGS-1:0];
  assign tick_emit  = any_logged || (run_r == RUN_LIMIT);
  assign run_tick   = tick_emit ? RUN_ONE : run_r + 8'd1;

  // Build the command for the back end
  always_comb begin
    push_cmd.hdr      = (kind == KIND_START);
    push_cmd.sep1_en  = (kind != KIND_START) && tick_emit;
    push_cmd.sep1_run = run_r;
    push_cmd.marks    = marks_r[LOGGED_REGS-1:0];
    push_cmd.vals     = vals_r[LOGGED_REGS-1:0];
    push_cmd.sep2_en  = (kind == KIND_STOP);
    push_cmd.sep2_run = run_tick;
  end

  always_comb begin
    push = 1'b0;
    if (acc) begin
      case (kind)
        KIND_START: push = !rec_r;
        KIND_TICK:  push = rec_r && tick_emit;
        KIND_STOP:  push = rec_r;
        default:    push = 1'b0;
      endcase
    end
  end

  // Capture first write per register in a frame
  always_ff @(posedge clk) begin
    if (acc && (kind == KIND_WRITE) && !marks_r[in_chan.reg_index]) begin
      vals_r[in_chan.reg_index] <= in_chan.reg_value;
    end
  end

  // Update marks, empty-frame run and recording flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marks_r <= '0;
      run_r   <= RUN_ONE;
      rec_r   <= 1'b0;
    end else if (acc) begin
      case (kind)
        KIND_WRITE: begin
          marks_r[in_chan.reg_index] <= 1'b1;
        end
        KIND_TICK: begin
          if (rec_r) begin
            run_r   <= run_tick;
            marks_r <= '0;
          end
        end
        KIND_START: begin
          if (!rec_r) begin
            marks_r <= '0;
            run_r   <= RUN_ONE;
            rec_r   <= 1'b1;
          end
        end
        default: begin
          if (rec_r) begin
            run_r   <= run_tick;
            marks_r <= '0;
            rec_r   <= 1'b0;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/slre_back.sv */
`default_nettype none

module slre_back import slre_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cmd_t       head,
  input  wire fifo_stat_t stat,
  output logic            pop,
  slre_out_if.source      out_chan
);

  back_phase_t             phase_r;
  back_phase_t             phase_nxt;
  back_phase_t             follow;
  back_phase_t             start_phase;
  back_phase_t             after_sep1;
  back_phase_t             after_pair;
  cmd_t                    cmd_r;
  logic [LOGGED_REGS-1:0]  pend_r;
  logic [LOGGED_REGS-1:0]  pend_clr;
  logic [HDR_CNT_W-1:0]    hdr_cnt_r;
  logic [BYTE_CNT_W-1:0]   byte_cnt_r;
  logic [LOG_IDX_W-1:0]    sel;
  logic                    adv;
  logic [7:0]              byte_val;
  logic                    out_valid_r;
  logic [7:0]              out_byte_r;
  logic                    out_last_r;

  assign pop      = (phase_r == PH_IDLE) && !stat.empty;
  assign adv      = (phase_r != PH_IDLE) && (!out_valid_r || out_chan.ready);
  assign pend_clr = pend_r & (pend_r - LOGGED_REGS'(1));

  // Lowest pending register
  always_comb begin
    sel = '0;
    for (int i = LOGGED_REGS - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        sel = LOG_IDX_W'(i);
      end
    end
  end

  // Next phase
  always_comb begin
    after_sep1 = (|pend_r) ? PH_PAIR_IDX : (cmd_r.sep2_en ? PH_SEP2_TAG : PH_IDLE);
    after_pair = (|pend_clr) ? PH_PAIR_IDX : (cmd_r.sep2_en ? PH_SEP2_TAG : PH_IDLE);

    if (head.hdr) begin
      start_phase = PH_HDR;
    end else if (head.sep1_en) begin
      start_phase = PH_SEP1_TAG;
    end else if (|head.marks) begin
      start_phase = PH_PAIR_IDX;
    end else begin
      start_phase = PH_SEP2_TAG;
    end

    case (phase_r)
      PH_HDR:      follow = (hdr_cnt_r == HDR_CNT_W'(HDR_LEN - 1)) ? PH_IDLE : PH_HDR;
      PH_SEP1_TAG: follow = (cmd_r.sep1_run == RUN_ONE) ? after_sep1 : PH_SEP1_CNT;
      PH_SEP1_CNT: follow = after_sep1;
      PH_PAIR_IDX: follow = PH_PAIR_VAL;
      PH_PAIR_VAL: follow = after_pair;
      PH_SEP2_TAG: follow = (cmd_r.sep2_run == RUN_ONE) ? PH_IDLE : PH_SEP2_CNT;
      default:     follow = PH_IDLE;
    endcase
    // Drop anything beyond the per-item byte limit
    if (byte_cnt_r == BYTE_CNT_W'(MAX_RESULTS - 1)) begin
      follow = PH_IDLE;
    end

    if (phase_r == PH_IDLE) begin
      phase_nxt = pop ? start_phase : PH_IDLE;
    end else begin
      phase_nxt = adv ? follow : phase_r;
    end
  end

  // Byte for the current phase
  always_comb begin
    case (phase_r)
      PH_HDR:      byte_val = hdr_byte(hdr_cnt_r);
      PH_SEP1_TAG: byte_val = sep_tag(cmd_r.sep1_run);
      PH_SEP1_CNT: byte_val = cmd_r.sep1_run;
      PH_PAIR_IDX: byte_val = 8'(sel);
      PH_PAIR_VAL: byte_val = cmd_r.vals[sel];
      PH_SEP2_TAG: byte_val = sep_tag(cmd_r.sep2_run);
      PH_SEP2_CNT: byte_val = cmd_r.sep2_run;
      default:     byte_val = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // Load a command, then walk its bytes
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r      <= head;
      pend_r     <= head.marks;
      hdr_cnt_r  <= '0;
      byte_cnt_r <= '0;
    end else if (adv) begin
      byte_cnt_r <= byte_cnt_r + 1'b1;
      if (phase_r == PH_HDR) begin
        hdr_cnt_r <= hdr_cnt_r + 1'b1;
      end
      if (phase_r == PH_PAIR_VAL) begin
        pend_r <= pend_clr;
      end
    end
  end

  // Output register: hold until transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= byte_val;
      out_last_r <= (follow == PH_IDLE);
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_byte = out_byte_r;
  assign out_chan.last     = out_last_r;

endmodule

`default_nettype wire

/* rtl/core/sound_register_log_encoder.sv */
// Turns sound-chip register writes and frame ticks into a register-dump
// byte log, one byte per output transfer with last set on the final byte
// an item causes. A register write produces nothing. A tick, start or
// stop that produces output is queued as a command in a two-entry queue;
// the byte sequencer then loads it and emits its bytes (up to 32 per item,
// 16 for the header), paced by its single output byte register. Input
// items are taken every cycle while the queue has room, so writes for the
// next frame keep flowing while the previous frame is being sent.
`default_nettype none
`include "sound_register_log_encoder_defines.svh"

module sound_register_log_encoder import slre_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  slre_in_if.sink    in_chan,
  slre_out_if.source out_chan
);

  logic       push;
  logic       pop;
  cmd_t       push_cmd;
  cmd_t       head;
  fifo_stat_t stat;

  slre_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .stat     (stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  slre_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  slre_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .stat     (stat),
    .pop      (pop),
    .out_chan (out_chan)
  );

  `SLRE_ASSERT_IMPL(a_no_push_full, push, !stat.full, "command pushed into full queue")
  `SLRE_ASSERT_IMPL(a_no_pop_empty, pop, !stat.empty, "command popped from empty queue")
  `SLRE_ASSERT_IMPL(a_push_on_xfer, push, in_chan.valid && in_chan.ready, "push without transfer")
  `SLRE_ASSERT_NEXT(a_pop_not_full, pop && !push, !stat.full, "queue full right after pop")

endmodule

`default_nettype wire

/* sim/sound_register_log_encoder_test.sv */
module sound_register_log_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import slre_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_OFF    = 300;
  localparam int SETTLE      = 40;

  // Expected log byte with its end-of-item flag
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } log_byte_t;

  localparam logic [7:0] FILE_MAGIC [4] = '{8'h50, 8'h53, 8'h47, 8'h1a};

  logic clk;
  logic rst_n;

  slre_in_if  in_chan ();
  slre_out_if out_chan ();

  sound_register_log_encoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Shadow copy of the encoder state
  logic [7:0] shadow_values [REG_SLOTS];
  logic       shadow_marks  [REG_SLOTS];
  logic [7:0] shadow_run;
  logic       shadow_recording;

  logic [7:0] item_bytes [$];
  log_byte_t  log_due [$];

  int  error_count   = 0;
  int  items_sent    = 0;
  int  bytes_checked = 0;
  int  quiet_cycles  = 0;
  int  hold_cycles   = 0;
  int  stall_left    = 0;
  bit  send_idle     = 1'b1;
  bit  recv_idle     = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Log prediction
  // ---------------------------------------------------------------------

  function void add_byte(input logic [7:0] b);
    if (item_bytes.size() < MAX_RESULTS) item_bytes.push_back(b);
  endfunction

  // FF after one frame, FE plus count after more
  function void add_separator();
    if (shadow_run > 8'd1) begin
      add_byte(SEP_RUN);
      add_byte(shadow_run);
    end else if (shadow_run == 8'd1) begin
      add_byte(SEP_ONE);
    end
  endfunction

  function void close_frame();
    bit any_logged;
    any_logged = 1'b0;
    if (!shadow_recording) return;
    for (int i = 0; i < LOGGED_REGS; i++) if (shadow_marks[i]) any_logged = 1'b1;
    if (any_logged) begin
      add_separator();
      for (int i = 0; i < LOGGED_REGS; i++) begin
        if (shadow_marks[i]) begin
          add_byte(8'(i));
          add_byte(shadow_values[i]);
        end
      end
      shadow_run = 8'd1;
    end else if (shadow_run >= RUN_LIMIT) begin
      // flush a saturated empty run early
      add_byte(SEP_RUN);
      add_byte(RUN_LIMIT);
      shadow_run = 8'd1;
    end else begin
      shadow_run = shadow_run + 8'd1;
    end
    for (int i = 0; i < REG_SLOTS; i++) shadow_marks[i] = 1'b0;
  endfunction

  function void predict_log_bytes(input kind_t kind, input logic [3:0] idx,
                                  input logic [7:0] val);
    item_bytes.delete();
    case (kind)
      KIND_WRITE: begin
        // keep only the first write per frame
        if (!shadow_marks[idx]) begin
          shadow_values[idx] = val;
          shadow_marks[idx]  = 1'b1;
        end
      end
      KIND_TICK: close_frame();
      KIND_START: begin
        if (!shadow_recording) begin
          for (int i = 0; i < HDR_LEN; i++) add_byte((i < 4) ? FILE_MAGIC[i] : 8'h00);
          for (int i = 0; i < REG_SLOTS; i++) shadow_marks[i] = 1'b0;
          shadow_run       = 8'd1;
          shadow_recording = 1'b1;
        end
      end
      default: begin
        if (shadow_recording) begin
          close_frame();
          add_separator();
          shadow_recording = 1'b0;
        end
      end
    endcase
    foreach (item_bytes[i]) log_due.push_back('{item_bytes[i], i == item_bytes.size() - 1});
  endfunction

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // Entered and left at a falling edge; valid is dropped after the transfer
  // and raised again at once when the next item follows directly.
  task automatic send_item(input kind_t kind, input logic [3:0] idx, input logic [7:0] val);
    if (send_idle && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 10)) @(negedge clk);
    in_chan.valid     = 1'b1;
    in_chan.kind      = kind;
    in_chan.reg_index = idx;
    in_chan.reg_value = val;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    predict_log_bytes(kind, idx, val);
    items_sent++;
    @(negedge clk);
    in_chan.valid = 1'b0;
  endtask

  task automatic send_noise();
    send_item(kind_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
              8'($urandom_range(0, 255)));
  endtask

  // Random writes followed by the tick that closes the frame
  task automatic send_frame(input int writes);
    for (int w = 0; w < writes; w++)
      send_item(KIND_WRITE, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    send_item(KIND_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    while (log_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------

  // Drive ready: a long hold-off when one is requested, else random stall bursts
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_chan.ready = 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_chan.ready = 1'b0;
        stall_left--;
      end else begin
        out_chan.ready = 1'b1;
        if (recv_idle && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 10);
      end
    end
  end

  // Compare each output transfer with the oldest expected byte
  always @(posedge clk) begin : check_log
    log_byte_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      bytes_checked++;
      if (log_due.size() == 0) begin
        $display("%0t: unexpected byte: expected none, actual byte %h last %b",
                 $time, out_chan.out_byte, out_chan.last);
        error_count++;
      end else begin
        want = log_due.pop_front();
        if (out_chan.out_byte !== want.data) begin
          $display("%0t: out_byte mismatch: expected %h, actual %h",
                   $time, want.data, out_chan.out_byte);
          error_count++;
        end
        if (out_chan.last !== want.last) begin
          $display("%0t: last mismatch on byte %h: expected %b, actual %b",
                   $time, want.data, want.last, out_chan.last);
          error_count++;
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d bytes still expected",
               $time, QUIET_LIMIT, log_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Writes, ticks and stops before recording, then a doubled start
  task automatic test_idle_behavior();
    send_item(KIND_WRITE, 4'd3, 8'haa);
    send_item(KIND_TICK, 4'd0, 8'h00);
    send_item(KIND_STOP, 4'd0, 8'h00);
    send_item(KIND_START, 4'd0, 8'h00);
    send_item(KIND_START, 4'd15, 8'hff);
    send_item(KIND_TICK, 4'd0, 8'h00);
  endtask

  // Field extremes, repeated writes, unlogged registers, a full frame
  task automatic test_register_extremes();
    send_item(KIND_WRITE, 4'd0, 8'h00);
    send_item(KIND_WRITE, 4'd0, 8'hff);
    send_item(KIND_WRITE, 4'd13, 8'hff);
    send_item(KIND_WRITE, 4'd14, 8'h55);
    send_item(KIND_WRITE, 4'd15, 8'haa);
    send_item(KIND_TICK, 4'd15, 8'hff);
    send_item(KIND_WRITE, 4'd14, 8'h12);
    send_item(KIND_WRITE, 4'd15, 8'h34);
    send_item(KIND_TICK, 4'd0, 8'h00);
    for (int i = 0; i < REG_SLOTS; i++) send_item(KIND_WRITE, 4'(i), ~8'(i * 17));
    send_item(KIND_TICK, 4'd0, 8'h00);
    send_item(KIND_STOP, 4'd0, 8'h00);
  endtask

  // Saturate the empty-frame counter, then log a frame after a short gap
  task automatic test_long_empty_run();
    send_item(KIND_START, 4'd0, 8'h00);
    repeat (255) send_item(KIND_TICK, 4'd0, 8'h00);
    repeat (3) send_item(KIND_TICK, 4'd0, 8'h00);
    send_item(KIND_WRITE, 4'd7, 8'h5a);
    send_item(KIND_TICK, 4'd0, 8'h00);
    send_item(KIND_STOP, 4'd0, 8'h00);
  endtask

  // Mostly well-formed sessions with random content, plus noise
  task automatic test_random_frames(input int target);
    int first_item;
    int roll;
    first_item = items_sent;
    while (items_sent - first_item < target) begin
      if ($urandom_range(0, 7) == 0) begin
        send_idle = ($urandom_range(0, 2) != 0);
        recv_idle = ($urandom_range(0, 2) != 0);
      end
      roll = $urandom_range(0, 99);
      if (!shadow_recording) begin
        if (roll < 70) send_item(KIND_START, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        else send_noise();
      end else if (roll < 6) begin
        send_item(KIND_STOP, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      end else if (roll < 10) begin
        send_item(KIND_START, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      end else if (roll < 14) begin
        send_noise();
      end else if (roll < 24) begin
        send_frame(0);
      end else begin
        send_frame($urandom_range(1, 12));
      end
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // Hold the output off while full frames keep arriving
  task automatic test_backpressure();
    if (!shadow_recording) send_item(KIND_START, 4'd0, 8'h00);
    hold_cycles = HOLD_OFF;
    repeat (4) begin
      for (int i = 0; i < LOGGED_REGS; i++) send_item(KIND_WRITE, 4'(i), 8'($urandom_range(0, 255)));
      send_item(KIND_TICK, 4'd0, 8'h00);
    end
  endtask

  // Back-to-back traffic with no gaps on either side
  task automatic test_steady_stream();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    if (!shadow_recording) send_item(KIND_START, 4'd0, 8'h00);
    repeat (6) send_frame($urandom_range(0, 14));
    send_item(KIND_STOP, 4'd0, 8'h00);
  endtask

  initial begin
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.kind      = KIND_WRITE;
    in_chan.reg_index = 4'd0;
    in_chan.reg_value = 8'h00;
    for (int i = 0; i < REG_SLOTS; i++) begin
      shadow_values[i] = 8'h00;
      shadow_marks[i]  = 1'b0;
    end
    shadow_run       = 8'd1;
    shadow_recording = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_behavior();
    test_register_extremes();
    test_long_empty_run();
    test_random_frames(160);
    test_backpressure();
    test_steady_stream();
    wait_drained();

    $display("Run covered %0d input transfers and %0d log bytes: header, separators,",
             items_sent, bytes_checked);
    $display("unlogged registers, idle commands, saturated empty runs and output hold-off.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
